// ----- rtl/core/knss_pkg.sv -----
// Package for the k-nearest sample selector: sizes, widths and the
// control struct passed to the distance unit.
// No dependencies.
package knss_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int MAX_K       = 16;
    localparam int DIM         = 4;
    localparam int COORD_BITS  = 16;
    localparam int LABEL_BITS  = 8;

    localparam int IDX_BITS    = $clog2(MAX_SAMPLES);
    localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);
    localparam int K_BITS      = 5;
    localparam int DIM_BITS    = $clog2(DIM);
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int DIST_BITS   = 34;
    localparam int VEC_BITS    = DIM * COORD_BITS;
    localparam int ENTRY_BITS  = VEC_BITS + LABEL_BITS;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One dimension step into the distance unit.
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } knss_step_t;

endpackage

// ----- rtl/core/knss_in_if.sv -----
// Input channel of the k-nearest sample selector: valid/ready and item fields.
// Depends on knss_pkg.
interface knss_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      cmd;
    logic        [knss_pkg::LABEL_BITS-1:0]    item_label;
    logic signed [knss_pkg::COORD_BITS-1:0]    coord_0;
    logic signed [knss_pkg::COORD_BITS-1:0]    coord_1;
    logic signed [knss_pkg::COORD_BITS-1:0]    coord_2;
    logic signed [knss_pkg::COORD_BITS-1:0]    coord_3;
    logic        [knss_pkg::K_BITS-1:0]        neighbor_count;

    modport source (
        output valid, cmd, item_label, coord_0, coord_1, coord_2, coord_3,
               neighbor_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, item_label, coord_0, coord_1, coord_2, coord_3,
               neighbor_count,
        output ready
    );
endinterface

// ----- rtl/core/knss_out_if.sv -----
// Result channel of the k-nearest sample selector: valid/ready and result fields.
// Depends on knss_pkg.
interface knss_out_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      found;
    logic        [knss_pkg::IDX_BITS-1:0]      sample_index;
    logic        [knss_pkg::LABEL_BITS-1:0]    sample_label;
    logic signed [knss_pkg::COORD_BITS-1:0]    out_coord_0;
    logic signed [knss_pkg::COORD_BITS-1:0]    out_coord_1;
    logic signed [knss_pkg::COORD_BITS-1:0]    out_coord_2;
    logic signed [knss_pkg::COORD_BITS-1:0]    out_coord_3;
    logic        [knss_pkg::DIST_BITS-1:0]     squared_distance;
    logic                                      last;

    modport source (
        output valid, found, sample_index, sample_label, out_coord_0, out_coord_1,
               out_coord_2, out_coord_3, squared_distance, last,
        input  ready
    );
    modport sink (
        input  valid, found, sample_index, sample_label, out_coord_0, out_coord_1,
               out_coord_2, out_coord_3, squared_distance, last,
        output ready
    );
endinterface

// ----- rtl/core/knss_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module knss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/knss_dist_unit.sv -----
// Squared distance unit: one dimension per cycle through subtract, square
// and accumulate stages; emits one sum per sample.
// Depends on knss_pkg.
module knss_dist_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  knss_pkg::knss_step_t                 step,
    input  logic signed [knss_pkg::COORD_BITS-1:0] coord_a,
    input  logic signed [knss_pkg::COORD_BITS-1:0] coord_b,
    output logic                                 res_valid,
    output logic [knss_pkg::IDX_BITS-1:0]        res_idx,
    output logic [knss_pkg::DIST_BITS-1:0]       res_dist,
    output logic                                 busy
);

    knss_pkg::knss_step_t a_step_reg;
    knss_pkg::knss_step_t b_step_reg;

    logic signed [knss_pkg::DIFF_BITS-1:0]   diff_reg;
    logic signed [knss_pkg::DIFF_BITS-1:0]   diff_next;
    logic signed [2*knss_pkg::DIFF_BITS-1:0] prod;
    logic        [knss_pkg::DIST_BITS-1:0]   sq_reg;
    logic        [knss_pkg::DIST_BITS-1:0]   sq_next;
    logic        [knss_pkg::DIST_BITS-1:0]   acc_reg;
    logic        [knss_pkg::DIST_BITS-1:0]   acc_next;
    logic                                    res_valid_reg;
    logic                                    res_valid_next;
    logic        [knss_pkg::IDX_BITS-1:0]    res_idx_reg;

    always_comb
    begin
        diff_next = $signed({coord_a[knss_pkg::COORD_BITS-1], coord_a})
                  - $signed({coord_b[knss_pkg::COORD_BITS-1], coord_b});
        prod      = diff_reg * diff_reg;
        // square is never negative, so the low bits are the magnitude
        sq_next   = prod[knss_pkg::DIST_BITS-1:0];
        acc_next  = acc_reg;
        if (b_step_reg.valid)
        begin
            acc_next = b_step_reg.first ? sq_reg : acc_reg + sq_reg;
        end
        res_valid_next = b_step_reg.valid && b_step_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_step_reg    <= '0;
            b_step_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_step_reg    <= step;
            b_step_reg    <= a_step_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= diff_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        res_idx_reg <= b_step_reg.idx;
    end

    assign res_valid = res_valid_reg;
    assign res_idx   = res_idx_reg;
    assign res_dist  = acc_reg;
    assign busy      = a_step_reg.valid || b_step_reg.valid || res_valid_reg;

endmodule

// ----- rtl/core/k_nearest_sample_select.sv -----
// Top level of the k-nearest sample selector: sample store, distance store,
// query sequencer and result register.
// Depends on knss_pkg, knss_in_if, knss_out_if, knss_ram, knss_dist_unit.
//
//  channel  | dir | transfer
//  ---------+-----+-----------------------------------------------------------
//  item     | in  | load (append sample) or query (center, neighbor count)
//  result   | out | one selected sample per transfer, last marks query end
//
// A query over N stored samples asking for k first feeds every coordinate
// through the single distance multiplier, which handles one coordinate a
// cycle; then each of the k passes reads the distance store
// once per sample through its one read port. Item ready is high only while
// the sequencer is idle; a result waiting in the output register stalls the
// next pass only when that pass has its own result ready. Reset clears the
// stored count; no clearing pass is needed.
module k_nearest_sample_select (
    input  logic         clk,
    input  logic         rst_n,
    knss_in_if.sink      item,
    knss_out_if.source   result
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIST_RD = 3'd1;
    localparam logic [2:0] S_DIST    = 3'd2;
    localparam logic [2:0] S_DRAIN   = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_FETCH   = 3'd5;
    localparam logic [2:0] S_LOAD    = 3'd6;
    localparam logic [2:0] S_EMPTY   = 3'd7;

    localparam int IB = knss_pkg::IDX_BITS;
    localparam int CB = knss_pkg::CNT_BITS;
    localparam int KB = knss_pkg::K_BITS;
    localparam int WB = knss_pkg::COORD_BITS;

    logic [2:0]     state_reg, state_next;
    logic [CB-1:0]  stored_count_reg, stored_count_next;
    logic [knss_pkg::MAX_SAMPLES-1:0] taken_reg, taken_next;
    logic [KB-1:0]  k_reg, k_next;
    logic [KB-1:0]  j_reg, j_next;
    logic [IB-1:0]  dist_i_reg, dist_i_next;
    logic [knss_pkg::DIM_BITS-1:0] d_reg, d_next;
    logic [CB-1:0]  issue_reg, issue_next;
    logic           cmp_valid_reg, cmp_valid_next;
    logic           cmp_last_reg, cmp_last_next;
    logic [IB-1:0]  cmp_idx_reg, cmp_idx_next;
    logic           have_reg, have_next;
    logic [IB-1:0]  best_idx_reg, best_idx_next;
    logic [knss_pkg::DIST_BITS-1:0] best_d_reg, best_d_next;
    logic signed [WB-1:0] center_reg [knss_pkg::DIM];
    logic signed [WB-1:0] center_next [knss_pkg::DIM];

    logic           out_valid_reg, out_valid_next;
    logic           out_found_reg, out_found_next;
    logic [IB-1:0]  out_index_reg, out_index_next;
    logic [knss_pkg::LABEL_BITS-1:0] out_label_reg, out_label_next;
    logic signed [WB-1:0] out_coord_reg [knss_pkg::DIM];
    logic signed [WB-1:0] out_coord_next [knss_pkg::DIM];
    logic [knss_pkg::DIST_BITS-1:0] out_dist_reg, out_dist_next;
    logic           out_last_reg, out_last_next;

    logic           accept;
    logic           out_free;
    logic           out_load;
    logic [CB-1:0]  k_sat;
    logic [KB-1:0]  k_in;

    logic                            store_we;
    logic [IB-1:0]                   store_waddr;
    logic [knss_pkg::ENTRY_BITS-1:0] store_wdata;
    logic                            store_re;
    logic [IB-1:0]                   store_raddr;
    logic [knss_pkg::ENTRY_BITS-1:0] store_rdata;

    logic                            dist_re;
    logic [IB-1:0]                   dist_raddr;
    logic [knss_pkg::DIST_BITS-1:0]  dist_rdata;

    knss_pkg::knss_step_t            step;
    logic signed [WB-1:0]            step_a;
    logic signed [WB-1:0]            step_b;
    logic                            res_valid;
    logic [IB-1:0]                   res_idx;
    logic [knss_pkg::DIST_BITS-1:0]  res_dist;
    logic                            dist_busy;

    knss_ram #(
        .WIDTH (knss_pkg::ENTRY_BITS),
        .DEPTH (knss_pkg::MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    knss_ram #(
        .WIDTH (knss_pkg::DIST_BITS),
        .DEPTH (knss_pkg::MAX_SAMPLES)
    ) u_dist_store (
        .clk   (clk),
        .we    (res_valid),
        .waddr (res_idx),
        .wdata (res_dist),
        .re    (dist_re),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    knss_dist_unit u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .coord_a   (step_a),
        .coord_b   (step_b),
        .res_valid (res_valid),
        .res_idx   (res_idx),
        .res_dist  (res_dist),
        .busy      (dist_busy)
    );

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next        = state_reg;
        stored_count_next = stored_count_reg;
        taken_next        = taken_reg;
        k_next            = k_reg;
        j_next            = j_reg;
        dist_i_next       = dist_i_reg;
        d_next            = d_reg;
        issue_next        = issue_reg;
        cmp_valid_next    = 1'b0;
        cmp_last_next     = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        have_next         = have_reg;
        best_idx_next     = best_idx_reg;
        best_d_next       = best_d_reg;
        center_next       = center_reg;

        out_load          = 1'b0;
        out_valid_next    = out_valid_reg && !result.ready;
        out_found_next    = out_found_reg;
        out_index_next    = out_index_reg;
        out_label_next    = out_label_reg;
        out_coord_next    = out_coord_reg;
        out_dist_next     = out_dist_reg;
        out_last_next     = out_last_reg;

        store_we    = 1'b0;
        store_waddr = stored_count_reg[IB-1:0];
        store_wdata = {item.item_label, item.coord_3, item.coord_2,
                       item.coord_1, item.coord_0};
        store_re    = 1'b0;
        store_raddr = '0;
        dist_re     = 1'b0;
        dist_raddr  = issue_reg[IB-1:0];

        step        = '0;
        step.idx    = dist_i_reg;
        step_a      = store_rdata[d_reg*WB +: WB];
        step_b      = center_reg[d_reg];

        // neighbor count: zero means one, then saturate to MAX_K and the store
        k_in  = (item.neighbor_count == '0) ? KB'(1) : item.neighbor_count;
        k_sat = (CB'(k_in) > CB'(knss_pkg::MAX_K)) ? CB'(knss_pkg::MAX_K) : CB'(k_in);
        if (k_sat > stored_count_reg)
        begin
            k_sat = stored_count_reg;
        end

        // running minimum over the distance store
        if (cmp_valid_reg)
        begin
            if (!taken_reg[cmp_idx_reg] && (!have_reg || dist_rdata < best_d_reg))
            begin
                have_next     = 1'b1;
                best_idx_next = cmp_idx_reg;
                best_d_next   = dist_rdata;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == knss_pkg::CMD_LOAD)
                    begin
                        if (stored_count_reg < CB'(knss_pkg::MAX_SAMPLES))
                        begin
                            store_we          = 1'b1;
                            stored_count_next = stored_count_reg + CB'(1);
                        end
                    end
                    else
                    begin
                        taken_next     = '0;
                        center_next[0] = item.coord_0;
                        center_next[1] = item.coord_1;
                        center_next[2] = item.coord_2;
                        center_next[3] = item.coord_3;
                        k_next         = k_sat[KB-1:0];
                        j_next         = '0;
                        state_next     = (stored_count_reg == '0) ? S_EMPTY : S_DIST_RD;
                    end
                end
            end
            S_DIST_RD:
            begin
                store_re    = 1'b1;
                store_raddr = '0;
                dist_i_next = '0;
                d_next      = '0;
                state_next  = S_DIST;
            end
            S_DIST:
            begin
                step.valid = 1'b1;
                step.first = (d_reg == '0);
                step.last  = (d_reg == knss_pkg::DIM_BITS'(knss_pkg::DIM - 1));
                if (step.last)
                begin
                    d_next = '0;
                    if ({1'b0, dist_i_reg} == stored_count_reg - CB'(1))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        // next sample arrives as the current one finishes
                        store_re    = 1'b1;
                        store_raddr = dist_i_reg + IB'(1);
                        dist_i_next = dist_i_reg + IB'(1);
                    end
                end
                else
                begin
                    d_next = d_reg + knss_pkg::DIM_BITS'(1);
                end
            end
            S_DRAIN:
            begin
                if (!dist_busy)
                begin
                    issue_next = '0;
                    have_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue_reg != stored_count_reg)
                begin
                    dist_re        = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IB-1:0];
                    cmp_last_next  = (issue_reg == stored_count_reg - CB'(1));
                    issue_next     = issue_reg + CB'(1);
                end
                if (cmp_valid_reg && cmp_last_reg)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                store_re    = 1'b1;
                store_raddr = best_idx_reg;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_index_next = best_idx_reg;
                    out_label_next = store_rdata[knss_pkg::VEC_BITS +: knss_pkg::LABEL_BITS];
                    for (int d = 0; d < knss_pkg::DIM; d++)
                    begin
                        out_coord_next[d] = store_rdata[d*WB +: WB];
                    end
                    out_dist_next  = best_d_reg;
                    out_last_next  = (j_reg == k_reg - KB'(1));
                    taken_next[best_idx_reg] = 1'b1;
                    if (j_reg == k_reg - KB'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + KB'(1);
                        issue_next = '0;
                        have_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_index_next = '0;
                    out_label_next = '0;
                    for (int d = 0; d < knss_pkg::DIM; d++)
                    begin
                        out_coord_next[d] = '0;
                    end
                    out_dist_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            stored_count_reg <= '0;
            taken_reg        <= '0;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            taken_reg        <= taken_next;
            cmp_valid_reg    <= cmp_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        j_reg         <= j_next;
        dist_i_reg    <= dist_i_next;
        d_reg         <= d_next;
        issue_reg     <= issue_next;
        cmp_last_reg  <= cmp_last_next;
        cmp_idx_reg   <= cmp_idx_next;
        have_reg      <= have_next;
        best_idx_reg  <= best_idx_next;
        best_d_reg    <= best_d_next;
        center_reg    <= center_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_label_reg <= out_label_next;
        out_coord_reg <= out_coord_next;
        out_dist_reg  <= out_dist_next;
        out_last_reg  <= out_last_next;
    end

    assign item.ready              = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.found            = out_found_reg;
    assign result.sample_index     = out_index_reg;
    assign result.sample_label     = out_label_reg;
    assign result.out_coord_0      = out_coord_reg[0];
    assign result.out_coord_1      = out_coord_reg[1];
    assign result.out_coord_2      = out_coord_reg[2];
    assign result.out_coord_3      = out_coord_reg[3];
    assign result.squared_distance = out_dist_reg;
    assign result.last             = out_last_reg;

`ifndef NO_ASSERTIONS
    a_pick_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && out_load) |-> !taken_reg[best_idx_reg])
        else $error("selected sample already reported in this query");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CB'(knss_pkg::MAX_SAMPLES))
        else $error("stored count beyond store depth");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!dist_busy && !cmp_valid_reg))
        else $error("distance or scan work left over in idle");

    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_FETCH || state_reg == S_LOAD)
        |-> (j_reg < k_reg))
        else $error("pass count beyond neighbor count");

    a_store_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(stored_count_reg))
        else $error("store changed during a query");
`endif

endmodule
